FILE: hw/rtl/ihex_pkg.sv
// shared types and constants for the hex record parser
// no dependencies; used by every module of the block
package ihex_pkg;

    localparam int ADDR_W     = 17;
    localparam int BYTE_W     = 8;
    localparam int NIBBLE_W   = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [ADDR_W-1:0] LOWEST_RESET  = 17'd65535;
    localparam logic [ADDR_W-1:0] HIGHEST_RESET = 17'd0;

    localparam logic [BYTE_W-1:0] CHAR_COLON   = 8'h3A;
    localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [BYTE_W-1:0] REC_TYPE_DATA = 8'h00;
    localparam logic [BYTE_W-1:0] REC_TYPE_EOF  = 8'h01;
    localparam logic [BYTE_W-1:0] ADDR_BYTES    = 8'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_LOWEST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_HIGHEST = 2'd1;

    typedef enum logic [3:0] {
        PH_COLON = 4'd0,
        PH_LEN   = 4'd1,
        PH_ADDR  = 4'd2,
        PH_TYPE  = 4'd3,
        PH_DATA  = 4'd4,
        PH_CKSUM = 4'd5,
        PH_SKIP  = 4'd6
    } phase_t;

    typedef enum logic [2:0] {
        KIND_WRITE  = 3'd0,
        KIND_OK     = 3'd1,
        KIND_EOF    = 3'd2,
        KIND_FORMAT = 3'd3,
        KIND_CKSUM  = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [ADDR_W-1:0]  write_address;
        logic [BYTE_W-1:0]  write_data;
        logic [ADDR_W-1:0]  lowest_address;
        logic [ADDR_W-1:0]  highest_address;
    } result_t;

endpackage

FILE: hw/rtl/ihex_in_reg.sv
// input register for the character channel
// depends on ihex_pkg for widths
module ihex_in_reg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [ihex_pkg::BYTE_W-1:0] character,
    input  logic                        advance,
    output logic                        item_valid,
    output logic [ihex_pkg::BYTE_W-1:0] item_char
);

    logic                        valid_reg;
    logic                        valid_next;
    logic [ihex_pkg::BYTE_W-1:0] char_reg;

    // held item blocks the channel only while the parser cannot move
    assign in_stall   = valid_reg && !advance;
    assign valid_next = in_stall ? valid_reg : in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            char_reg <= character;
        end
    end

    assign item_valid = valid_reg;
    assign item_char  = char_reg;

endmodule

FILE: hw/rtl/ihex_parser.sv
// record parser state and per-character update logic
// depends on ihex_pkg for phase, kind and result types
module ihex_parser (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            take,
    input  logic [ihex_pkg::BYTE_W-1:0]     item_char,
    input  logic                            cfg_we,
    input  logic [ihex_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ihex_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                            res_valid,
    output ihex_pkg::result_t               res
);

    ihex_pkg::phase_t               phase_reg, phase_next;
    logic                           half_reg, half_next;
    logic [ihex_pkg::NIBBLE_W-1:0]  nib_reg, nib_next;
    logic [ihex_pkg::BYTE_W-1:0]    len_reg, len_next;
    logic [ihex_pkg::BYTE_W-1:0]    left_reg, left_next;
    logic [ihex_pkg::ADDR_W-1:0]    cursor_reg, cursor_next;
    logic [ihex_pkg::BYTE_W-1:0]    type_reg, type_next;
    logic [ihex_pkg::BYTE_W-1:0]    sum_reg, sum_next;
    logic [ihex_pkg::ADDR_W-1:0]    low_reg, low_next;
    logic [ihex_pkg::ADDR_W-1:0]    high_reg, high_next;
    logic                           halt_reg, halt_next;

    logic                           digit_ok;
    logic [ihex_pkg::NIBBLE_W-1:0]  digit;
    logic [ihex_pkg::BYTE_W-1:0]    byte_val;
    logic [ihex_pkg::BYTE_W-1:0]    sum_add;
    logic [ihex_pkg::BYTE_W-1:0]    left_dec;
    logic [ihex_pkg::ADDR_W-1:0]    addr_shift;

    // hex digit decode, upper and lower case
    always_comb
    begin
        digit_ok = 1'b1;
        digit    = '0;
        if (item_char >= 8'h30 && item_char <= 8'h39)
        begin
            digit = 4'(item_char - 8'h30);
        end
        else if (item_char >= 8'h41 && item_char <= 8'h46)
        begin
            digit = 4'(item_char - 8'h37);
        end
        else if (item_char >= 8'h61 && item_char <= 8'h66)
        begin
            digit = 4'(item_char - 8'h57);
        end
        else
        begin
            digit_ok = 1'b0;
        end
    end

    assign byte_val   = {nib_reg, digit};
    assign sum_add    = 8'(sum_reg + byte_val);
    assign left_dec   = 8'(left_reg - 8'd1);
    assign addr_shift = {cursor_reg[ihex_pkg::ADDR_W-ihex_pkg::BYTE_W-1:0], byte_val};

    always_comb
    begin
        phase_next  = phase_reg;
        half_next   = half_reg;
        nib_next    = nib_reg;
        len_next    = len_reg;
        left_next   = left_reg;
        cursor_next = cursor_reg;
        type_next   = type_reg;
        sum_next    = sum_reg;
        low_next    = low_reg;
        high_next   = high_reg;
        halt_next   = halt_reg;
        res_valid   = 1'b0;
        res.kind          = ihex_pkg::KIND_OK;
        res.write_address = '0;
        res.write_data    = '0;

        if (take && !halt_reg)
        begin
            if (phase_reg == ihex_pkg::PH_COLON)
            begin
                if (item_char != ihex_pkg::CHAR_COLON)
                begin
                    halt_next = 1'b1;
                    res_valid = 1'b1;
                    res.kind  = ihex_pkg::KIND_FORMAT;
                end
                else
                begin
                    half_next  = 1'b0;
                    phase_next = ihex_pkg::PH_LEN;
                end
            end
            else if (phase_reg == ihex_pkg::PH_SKIP)
            begin
                if (item_char == ihex_pkg::CHAR_NEWLINE)
                begin
                    phase_next = ihex_pkg::PH_COLON;
                end
            end
            else if (!digit_ok)
            begin
                // also catches a newline before the checksum
                halt_next = 1'b1;
                res_valid = 1'b1;
                res.kind  = ihex_pkg::KIND_FORMAT;
            end
            else if (!half_reg)
            begin
                nib_next  = digit;
                half_next = 1'b1;
            end
            else
            begin
                half_next = 1'b0;
                case (phase_reg)
                    ihex_pkg::PH_LEN:
                    begin
                        len_next    = byte_val;
                        sum_next    = byte_val;
                        cursor_next = '0;
                        left_next   = ihex_pkg::ADDR_BYTES;
                        phase_next  = ihex_pkg::PH_ADDR;
                    end
                    ihex_pkg::PH_ADDR:
                    begin
                        cursor_next = addr_shift;
                        sum_next    = sum_add;
                        left_next   = left_dec;
                        if (left_dec == 8'd0)
                        begin
                            if (addr_shift < low_reg)
                            begin
                                low_next = addr_shift;
                            end
                            if (addr_shift > high_reg)
                            begin
                                high_next = addr_shift;
                            end
                            phase_next = ihex_pkg::PH_TYPE;
                        end
                    end
                    ihex_pkg::PH_TYPE:
                    begin
                        type_next = byte_val;
                        sum_next  = sum_add;
                        if (byte_val == ihex_pkg::REC_TYPE_EOF)
                        begin
                            halt_next = 1'b1;
                            res_valid = 1'b1;
                            res.kind  = ihex_pkg::KIND_EOF;
                        end
                        else
                        begin
                            left_next  = len_reg;
                            phase_next = (len_reg != 8'd0) ? ihex_pkg::PH_DATA
                                                           : ihex_pkg::PH_CKSUM;
                        end
                    end
                    ihex_pkg::PH_DATA:
                    begin
                        sum_next = sum_add;
                        if (type_reg == ihex_pkg::REC_TYPE_DATA)
                        begin
                            if (cursor_reg > high_reg)
                            begin
                                high_next = cursor_reg;
                            end
                            res_valid         = 1'b1;
                            res.kind          = ihex_pkg::KIND_WRITE;
                            res.write_address = cursor_reg;
                            res.write_data    = byte_val;
                            cursor_next       = 17'(cursor_reg + 17'd1);
                        end
                        left_next = left_dec;
                        if (left_dec == 8'd0)
                        begin
                            phase_next = ihex_pkg::PH_CKSUM;
                        end
                    end
                    default:
                    begin
                        res_valid = 1'b1;
                        if (sum_add != 8'd0)
                        begin
                            halt_next = 1'b1;
                            res.kind  = ihex_pkg::KIND_CKSUM;
                        end
                        else
                        begin
                            phase_next = ihex_pkg::PH_SKIP;
                            res.kind   = ihex_pkg::KIND_OK;
                        end
                    end
                endcase
            end
        end

        res.lowest_address  = low_next;
        res.highest_address = high_next;

        // configuration loads the trackers directly
        if (cfg_we && cfg_index == ihex_pkg::CFG_INITIAL_LOWEST)
        begin
            low_next = cfg_data;
        end
        if (cfg_we && cfg_index == ihex_pkg::CFG_INITIAL_HIGHEST)
        begin
            high_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= ihex_pkg::PH_COLON;
            half_reg   <= 1'b0;
            nib_reg    <= '0;
            len_reg    <= '0;
            left_reg   <= '0;
            cursor_reg <= '0;
            type_reg   <= '0;
            sum_reg    <= '0;
            low_reg    <= ihex_pkg::LOWEST_RESET;
            high_reg   <= ihex_pkg::HIGHEST_RESET;
            halt_reg   <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            half_reg   <= half_next;
            nib_reg    <= nib_next;
            len_reg    <= len_next;
            left_reg   <= left_next;
            cursor_reg <= cursor_next;
            type_reg   <= type_next;
            sum_reg    <= sum_next;
            low_reg    <= low_next;
            high_reg   <= high_next;
            halt_reg   <= halt_next;
        end
    end

endmodule

FILE: hw/rtl/ihex_out_reg.sv
// result register for the output channel
// depends on ihex_pkg for the result type
module ihex_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              res_valid,
    input  ihex_pkg::result_t res,
    input  logic              out_stall,
    output logic              out_valid,
    output logic              advance,
    output ihex_pkg::result_t out_res
);

    logic              valid_reg;
    logic              valid_next;
    ihex_pkg::result_t res_reg;

    // slot can take a new result when empty or being drained this cycle
    assign advance    = !valid_reg || !out_stall;
    assign valid_next = advance ? res_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

FILE: hw/rtl/intel_hex_record_parser.sv
// top level of the hex record parser: input register, parser, result register
// depends on ihex_pkg, ihex_in_reg, ihex_parser and ihex_out_reg
// usage
//   input channel: one ascii character per transfer (in_valid, in_stall,
//   character); a newline ends a record line
//   output channel: zero or one result per character (out_valid, out_stall,
//   kind, write_address, write_data, lowest_address, highest_address)
//   kind: data write, record ok, end of file, format error, checksum error
//   config port: cfg_we with cfg_index 0 loads the lowest-address tracker,
//   index 1 the highest-address tracker; other indexes are ignored
// timing
//   one character per cycle sustained while the result slot is not stalled; the
//   parser state update is one short step between the input register and the
//   result register, and a result passes through both of those registers
// reset
//   waits for a colon, trackers at 65535 and 0, output empty
// stall
//   a stalled result holds; the input register keeps accepting until it
//   holds an item that cannot move, then in_stall rises
//   after end of file or any error every character is taken and dropped
module intel_hex_record_parser (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [ihex_pkg::BYTE_W-1:0]     character,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [2:0]                      kind,
    output logic [ihex_pkg::ADDR_W-1:0]     write_address,
    output logic [ihex_pkg::BYTE_W-1:0]     write_data,
    output logic [ihex_pkg::ADDR_W-1:0]     lowest_address,
    output logic [ihex_pkg::ADDR_W-1:0]     highest_address,
    input  logic                            cfg_we,
    input  logic [ihex_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ihex_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic                        advance;
    logic                        item_valid;
    logic [ihex_pkg::BYTE_W-1:0] item_char;
    logic                        res_valid;
    ihex_pkg::result_t           res;
    ihex_pkg::result_t           out_res;

    // character register in front of the parser
    ihex_in_reg u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .character  (character),
        .advance    (advance),
        .item_valid (item_valid),
        .item_char  (item_char)
    );

    // the held character is consumed whenever the result slot can move
    ihex_parser u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (item_valid && advance),
        .item_char (item_char),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res_valid (res_valid),
        .res       (res)
    );

    // result slot toward the receiver
    ihex_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .advance   (advance),
        .out_res   (out_res)
    );

    assign kind            = out_res.kind;
    assign write_address   = out_res.write_address;
    assign write_data      = out_res.write_data;
    assign lowest_address  = out_res.lowest_address;
    assign highest_address = out_res.highest_address;

endmodule

FILE: hw/rtl/ihex_checker.sv
// port-level checks for the hex record parser, bound to the top level
// depends on ihex_pkg and intel_hex_record_parser
module ihex_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_stall,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic [2:0]                  kind,
    input  logic [ihex_pkg::ADDR_W-1:0] write_address,
    input  logic [ihex_pkg::BYTE_W-1:0] write_data,
    input  logic [ihex_pkg::ADDR_W-1:0] highest_address
);

    // a terminal result leaves nothing behind it
    property p_halt_quiet;
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && (kind == ihex_pkg::KIND_EOF ||
            kind == ihex_pkg::KIND_FORMAT || kind == ihex_pkg::KIND_CKSUM))
        |=> !out_valid;
    endproperty
    a_halt_quiet: assert property (p_halt_quiet)
        else $error("result after end of file or error");

    property p_status_no_payload;
        @(posedge clk) disable iff (!rst_n)
        (out_valid && kind != ihex_pkg::KIND_WRITE)
        |-> (write_address == '0 && write_data == '0);
    endproperty
    a_status_no_payload: assert property (p_status_no_payload)
        else $error("status result carries write payload");

    property p_write_tracked;
        @(posedge clk) disable iff (!rst_n)
        (out_valid && kind == ihex_pkg::KIND_WRITE) |-> (highest_address >= write_address);
    endproperty
    a_write_tracked: assert property (p_write_tracked)
        else $error("highest address below written address");

    // input can only back up behind a full result slot
    property p_stall_cause;
        @(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall;
    endproperty
    a_stall_cause: assert property (p_stall_cause)
        else $error("input stalled with empty result slot");

    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(kind) &&
            $stable(write_address) && $stable(write_data));
    endproperty
    a_out_hold: assert property (p_out_hold)
        else $error("stalled result changed");

endmodule

bind intel_hex_record_parser ihex_checker u_ihex_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .kind            (kind),
    .write_address   (write_address),
    .write_data      (write_data),
    .highest_address (highest_address)
);

FILE: sim/intel_hex_record_parser_test.sv
// self-checking testbench for intel_hex_record_parser: hex text in, writes and status out
// depends on ihex_pkg and the intel_hex_record_parser rtl; holds its own parser model
`timescale 1ns / 100ps

module intel_hex_record_parser_test;

    localparam logic [ihex_pkg::ADDR_W-1:0]    ADDR_TOP        = 17'd65789;
    localparam logic [ihex_pkg::CFG_IDX_W-1:0] CFG_SPARE_2     = 2'd2;
    localparam logic [ihex_pkg::CFG_IDX_W-1:0] CFG_SPARE_3     = 2'd3;
    localparam int                             IDLE_PERCENT    = 24;
    localparam int                             SETTLE_CYCLES   = 8;
    localparam int                             HOLD_OFF_CYCLES = 400;
    localparam int                             CYCLE_LIMIT     = 200000;
    localparam int                             MAX_REPORTS     = 10;

    // ways of ending the hex stream; any of them halts the parser until reset
    typedef enum int {
        END_EOF,
        END_CKSUM,
        END_BAD_DIGIT,
        END_SHORT_LINE,
        END_NO_COLON
    } ending_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            in_valid = 1'b0;
    logic                            in_stall;
    logic [ihex_pkg::BYTE_W-1:0]     character = '0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic [2:0]                      kind;
    logic [ihex_pkg::ADDR_W-1:0]     write_address;
    logic [ihex_pkg::BYTE_W-1:0]     write_data;
    logic [ihex_pkg::ADDR_W-1:0]     lowest_address;
    logic [ihex_pkg::ADDR_W-1:0]     highest_address;
    logic                            cfg_we = 1'b0;
    logic [ihex_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [ihex_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    intel_hex_record_parser dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .character       (character),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .kind            (kind),
        .write_address   (write_address),
        .write_data      (write_data),
        .lowest_address  (lowest_address),
        .highest_address (highest_address),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // 20 ns period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // parser model state, reset values as the block comes out of reset
    ihex_pkg::phase_t            prs_phase   = ihex_pkg::PH_COLON;
    bit                          prs_half    = 1'b0;
    logic [3:0]                  prs_nibble  = '0;
    logic [7:0]                  rec_len     = '0;
    logic [7:0]                  bytes_left  = '0;
    logic [ihex_pkg::ADDR_W-1:0] cursor      = '0;
    logic [7:0]                  rec_type    = '0;
    logic [7:0]                  run_sum     = '0;
    logic [ihex_pkg::ADDR_W-1:0] trk_lowest  = ihex_pkg::LOWEST_RESET;
    logic [ihex_pkg::ADDR_W-1:0] trk_highest = ihex_pkg::HIGHEST_RESET;
    bit                          prs_halted  = 1'b0;

    // results the block owes, oldest first
    ihex_pkg::result_t pending_results[$];

    // control shared between the stimulus and the two handshake sides
    int unsigned       accepted_chars = 0;
    bit                typed_flag = 1'b0;
    ihex_pkg::result_t typed_want = '0;
    bit                no_idle = 1'b0;
    bit                draining = 1'b0;
    int                hold_cycles = 0;
    int                fail_count = 0;
    int unsigned       cycle_count = 0;

    // characters of the line being built
    logic [7:0] line_chars[$];

    // directed rows: a typed row gives the result of its last character
    string             script_text [6] = '{":02fFfF00aB", "Cd", "88", "\n",
                                           ":010000025aA3", "?\n"};
    bit                script_typed [6] = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
    ihex_pkg::result_t script_want [6] = '{
        '{ihex_pkg::KIND_WRITE, 17'h0FFFF, 8'hAB, 17'h0FFFF, 17'h0FFFF},
        '{ihex_pkg::KIND_WRITE, 17'h10000, 8'hCD, 17'h0FFFF, 17'h10000},
        '{ihex_pkg::KIND_OK,    17'h00000, 8'h00, 17'h0FFFF, 17'h10000},
        '0,
        '{ihex_pkg::KIND_OK,    17'h00000, 8'h00, 17'h00000, 17'h10000},
        '0
    };

    // a result stamped with the trackers as they stand now
    function automatic ihex_pkg::result_t tracker_result(input ihex_pkg::kind_t k,
                                                         input logic [ihex_pkg::ADDR_W-1:0] a,
                                                         input logic [7:0] d);
        ihex_pkg::result_t r;
        r.kind            = k;
        r.write_address   = a;
        r.write_data      = d;
        r.lowest_address  = trk_lowest;
        r.highest_address = trk_highest;
        return r;
    endfunction

    // one character through the parser model; returns 1 when a result comes out
    function automatic bit parse_char(input logic [7:0] c, output ihex_pkg::result_t r);
        logic [3:0] digit;
        logic [7:0] b;
        logic [7:0] total;
        bit         is_hex;
        bit         made;
        r = '0;
        if (prs_halted)
            return 1'b0;
        if (prs_phase == ihex_pkg::PH_COLON)
        begin
            if (c != ihex_pkg::CHAR_COLON)
            begin
                prs_halted = 1'b1;
                r = tracker_result(ihex_pkg::KIND_FORMAT, '0, '0);
                return 1'b1;
            end
            prs_half  = 1'b0;
            prs_phase = ihex_pkg::PH_LEN;
            return 1'b0;
        end
        // after a good checksum everything up to the newline is dropped
        if (prs_phase == ihex_pkg::PH_SKIP)
        begin
            if (c == ihex_pkg::CHAR_NEWLINE)
                prs_phase = ihex_pkg::PH_COLON;
            return 1'b0;
        end
        is_hex = 1'b1;
        digit  = '0;
        if (c >= "0" && c <= "9")
            digit = 4'(c - "0");
        else if (c >= "A" && c <= "F")
            digit = 4'(c - "A" + 8'd10);
        else if (c >= "a" && c <= "f")
            digit = 4'(c - "a" + 8'd10);
        else
            is_hex = 1'b0;
        // bad digit or a newline before the checksum is done
        if (!is_hex)
        begin
            prs_halted = 1'b1;
            r = tracker_result(ihex_pkg::KIND_FORMAT, '0, '0);
            return 1'b1;
        end
        if (!prs_half)
        begin
            prs_nibble = digit;
            prs_half   = 1'b1;
            return 1'b0;
        end
        prs_half = 1'b0;
        b = {prs_nibble, digit};
        made = 1'b0;
        case (prs_phase)
            ihex_pkg::PH_LEN:
            begin
                rec_len    = b;
                run_sum    = b;
                cursor     = '0;
                bytes_left = ihex_pkg::ADDR_BYTES;
                prs_phase  = ihex_pkg::PH_ADDR;
            end
            ihex_pkg::PH_ADDR:
            begin
                cursor     = {cursor[ihex_pkg::ADDR_W-9:0], b};
                run_sum    = run_sum + b;
                bytes_left = bytes_left - 8'd1;
                if (bytes_left == '0)
                begin
                    if (cursor < trk_lowest)
                        trk_lowest = cursor;
                    if (cursor > trk_highest)
                        trk_highest = cursor;
                    prs_phase = ihex_pkg::PH_TYPE;
                end
            end
            ihex_pkg::PH_TYPE:
            begin
                rec_type = b;
                run_sum  = run_sum + b;
                if (b == ihex_pkg::REC_TYPE_EOF)
                begin
                    prs_halted = 1'b1;
                    r = tracker_result(ihex_pkg::KIND_EOF, '0, '0);
                    return 1'b1;
                end
                bytes_left = rec_len;
                prs_phase  = (bytes_left != '0) ? ihex_pkg::PH_DATA : ihex_pkg::PH_CKSUM;
            end
            ihex_pkg::PH_DATA:
            begin
                run_sum = run_sum + b;
                // other record types only feed the sum
                if (rec_type == ihex_pkg::REC_TYPE_DATA)
                begin
                    if (cursor > trk_highest)
                        trk_highest = cursor;
                    r      = tracker_result(ihex_pkg::KIND_WRITE, cursor, b);
                    made   = 1'b1;
                    cursor = cursor + 1'b1;
                end
                bytes_left = bytes_left - 8'd1;
                if (bytes_left == '0)
                    prs_phase = ihex_pkg::PH_CKSUM;
            end
            default:
            begin
                total = run_sum + b;
                if (total != '0)
                begin
                    prs_halted = 1'b1;
                    r = tracker_result(ihex_pkg::KIND_CKSUM, '0, '0);
                    return 1'b1;
                end
                prs_phase = ihex_pkg::PH_SKIP;
                r    = tracker_result(ihex_pkg::KIND_OK, '0, '0);
                made = 1'b1;
            end
        endcase
        return made;
    endfunction

    task automatic note_failure(input string what, input ihex_pkg::result_t want,
                                input ihex_pkg::result_t got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%s at cycle %0d: expected kind %0d addr %0h data %0h low %0h high %0h",
                     what, cycle_count, want.kind, want.write_address, want.write_data,
                     want.lowest_address, want.highest_address);
        if (fail_count <= MAX_REPORTS)
            $display("    actual kind %0d addr %0h data %0h low %0h high %0h",
                     got.kind, got.write_address, got.write_data,
                     got.lowest_address, got.highest_address);
    endtask

    // everything the block does at a rising edge, seen with pre-edge values:
    // result transfers are checked first, then a character transfer feeds
    // the model, then a register write loads a tracker
    always @(posedge clk)
    begin : result_check
        ihex_pkg::result_t got;
        ihex_pkg::result_t want;
        ihex_pkg::result_t guess;
        bit                made;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got = '{ihex_pkg::kind_t'(kind), write_address, write_data,
                        lowest_address, highest_address};
                if (pending_results.size() == 0)
                begin
                    note_failure("result with nothing pending", '0, got);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.kind !== want.kind || got.write_address !== want.write_address ||
                        got.write_data !== want.write_data ||
                        got.lowest_address !== want.lowest_address ||
                        got.highest_address !== want.highest_address)
                        note_failure("result mismatch", want, got);
                end
            end
            if (in_valid && !in_stall)
            begin
                made = parse_char(character, guess);
                // a typed-in row overrides the model's result, state still follows the model
                if (typed_flag)
                    pending_results.push_back(typed_want);
                else if (made)
                    pending_results.push_back(guess);
                accepted_chars++;
            end
            if (cfg_we)
            begin
                if (cfg_index == ihex_pkg::CFG_INITIAL_LOWEST)
                    trk_lowest = cfg_data;
                else if (cfg_index == ihex_pkg::CFG_INITIAL_HIGHEST)
                    trk_highest = cfg_data;
            end
        end
    end

    // receiver side: a long hold-off when asked, none while draining or in
    // the quiet stretch, otherwise stalls at random
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_stall = 1'b1;
            hold_cycles--;
        end
        else if (draining || no_idle)
        begin
            out_stall = 1'b0;
        end
        else
        begin
            out_stall = ($urandom_range(0, 99) < IDLE_PERCENT);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("intel_hex_record_parser regression: fail");
            $finish;
        end
    end

    // one character transfer, entered and left at a falling edge
    task automatic send_char(input logic [7:0] c, input bit typed,
                             input ihex_pkg::result_t want);
        int          gap;
        int unsigned target;
        gap = 0;
        if (!no_idle)
            while ($urandom_range(0, 99) < IDLE_PERCENT)
                gap++;
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   = 1'b1;
        character  = c;
        typed_flag = typed;
        typed_want = want;
        target     = accepted_chars + 1;
        do
            @(negedge clk);
        while (accepted_chars != target);
    endtask

    task automatic send_line();
        foreach (line_chars[i])
            send_char(line_chars[i], 1'b0, '0);
    endtask

    // hex digit with a random letter case
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return "0" + n;
        return ($urandom_range(0, 1) ? "A" : "a") + n - 8'd10;
    endfunction

    task automatic put_hex(input logic [7:0] b);
        line_chars.push_back(hex_char(b[7:4]));
        line_chars.push_back(hex_char(b[3:0]));
    endtask

    // colon, header, data and checksum; the newline is left to the caller
    task automatic build_record(input logic [7:0] len, input logic [15:0] addr,
                                input logic [7:0] rtype, input bit corrupt);
        logic [7:0] sum;
        logic [7:0] d;
        line_chars.delete();
        line_chars.push_back(ihex_pkg::CHAR_COLON);
        sum = len + addr[15:8] + addr[7:0] + rtype;
        put_hex(len);
        put_hex(addr[15:8]);
        put_hex(addr[7:0]);
        put_hex(rtype);
        repeat (len)
        begin
            d = 8'($urandom);
            sum = sum + d;
            put_hex(d);
        end
        sum = -sum;
        if (corrupt)
            sum = 8'(sum + $urandom_range(1, 255));
        put_hex(sum);
    endtask

    // well-formed records with random content until the budget of record
    // characters is spent; junk after the checksum is ignored and not counted
    task automatic random_records(input int budget);
        int          sent;
        int          roll;
        logic [7:0]  len;
        logic [15:0] addr;
        logic [7:0]  rtype;
        logic [7:0]  c;
        sent = 0;
        while (sent < budget)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 70)
                len = 8'($urandom_range(0, 4));
            else if (roll < 95)
                len = 8'($urandom_range(5, 16));
            else
                len = 8'($urandom_range(17, 40));
            roll = $urandom_range(0, 99);
            if (roll < 15)
                addr = 16'($urandom_range(16'hFF00, 16'hFFFF));
            else if (roll < 25)
                addr = 16'($urandom_range(0, 15));
            else
                addr = 16'($urandom);
            if ($urandom_range(0, 99) < 80)
                rtype = ihex_pkg::REC_TYPE_DATA;
            else
                rtype = 8'($urandom_range(2, 255));
            build_record(len, addr, rtype, 1'b0);
            sent += line_chars.size() + 1;
            if ($urandom_range(0, 99) < 25)
                repeat ($urandom_range(1, 3))
                begin
                    do
                        c = 8'($urandom);
                    while (c == ihex_pkg::CHAR_NEWLINE);
                    line_chars.push_back(c);
                end
            line_chars.push_back(ihex_pkg::CHAR_NEWLINE);
            send_line();
        end
    endtask

    // the one stream-ending event of the run, picked at random
    task automatic finish_stream();
        ending_t    how;
        int         cut;
        logic [7:0] c;
        how = ending_t'($urandom_range(0, 4));
        case (how)
            END_EOF:
                build_record(8'($urandom_range(0, 3)), 16'($urandom),
                             ihex_pkg::REC_TYPE_EOF, 1'b0);
            END_CKSUM:
                build_record(8'($urandom_range(0, 6)), 16'($urandom),
                             ihex_pkg::REC_TYPE_DATA, 1'b1);
            END_BAD_DIGIT:
            begin
                build_record(8'($urandom_range(0, 4)), 16'($urandom),
                             ihex_pkg::REC_TYPE_DATA, 1'b0);
                cut = $urandom_range(1, line_chars.size() - 1);
                while (line_chars.size() > cut)
                    void'(line_chars.pop_back());
                do
                    c = 8'($urandom);
                while (c == ihex_pkg::CHAR_NEWLINE || (c >= "0" && c <= "9") ||
                       (c >= "A" && c <= "F") || (c >= "a" && c <= "f"));
                line_chars.push_back(c);
            end
            END_SHORT_LINE:
            begin
                // newline lands before the last checksum digit
                build_record(8'($urandom_range(0, 4)), 16'($urandom),
                             ihex_pkg::REC_TYPE_DATA, 1'b0);
                cut = $urandom_range(1, line_chars.size() - 1);
                while (line_chars.size() > cut)
                    void'(line_chars.pop_back());
            end
            default:
            begin
                // anything but a colon at line start, a blank line included
                line_chars.delete();
                do
                    c = 8'($urandom);
                while (c == ihex_pkg::CHAR_COLON);
                line_chars.push_back(c);
            end
        endcase
        line_chars.push_back(ihex_pkg::CHAR_NEWLINE);
        send_line();
    endtask

    // stop offering, let every owed result out, then let the pipe settle
    task automatic drain();
        in_valid = 1'b0;
        draining = 1'b1;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        draining = 1'b0;
    endtask

    // register write while the block is idle
    task automatic write_reg(input logic [ihex_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ihex_pkg::CFG_DATA_W-1:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
        @(negedge clk);
    endtask

    initial
    begin : stimulus
        int r;
        int j;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // indexes past the two trackers must change nothing
        write_reg(CFG_SPARE_2, 17'($urandom_range(0, 17'h1FFFF)));
        write_reg(CFG_SPARE_3, 17'($urandom_range(0, 17'h1FFFF)));

        // directed: mixed-case digits, writes across the 64k boundary,
        // a skipped record type at address zero, junk after a checksum
        for (r = 0; r < 6; r++)
            for (j = 0; j < script_text[r].len(); j++)
                send_char(script_text[r][j],
                          script_typed[r] && (j == script_text[r].len() - 1),
                          script_want[r]);
        drain();

        // trackers at opposite extremes
        write_reg(ihex_pkg::CFG_INITIAL_LOWEST, ADDR_TOP);
        write_reg(ihex_pkg::CFG_INITIAL_HIGHEST, '0);
        random_records(300);
        drain();

        // receiver holds off while characters keep coming, so the input backs up
        write_reg(ihex_pkg::CFG_INITIAL_LOWEST, '0);
        write_reg(ihex_pkg::CFG_INITIAL_HIGHEST, ADDR_TOP);
        hold_cycles = HOLD_OFF_CYCLES;
        random_records(300);
        drain();

        // no idling on either side; the largest record reaches the top address
        write_reg(ihex_pkg::CFG_INITIAL_LOWEST, 17'($urandom_range(0, ADDR_TOP)));
        write_reg(ihex_pkg::CFG_INITIAL_HIGHEST, 17'($urandom_range(0, ADDR_TOP)));
        no_idle = 1'b1;
        build_record(8'd255, 16'hFFFF, ihex_pkg::REC_TYPE_DATA, 1'b0);
        line_chars.push_back(ihex_pkg::CHAR_NEWLINE);
        send_line();
        random_records(100);
        drain();
        no_idle = 1'b0;

        // back to the reset values
        write_reg(ihex_pkg::CFG_INITIAL_LOWEST, ihex_pkg::LOWEST_RESET);
        write_reg(ihex_pkg::CFG_INITIAL_HIGHEST, ihex_pkg::HIGHEST_RESET);
        random_records(200);

        // one halting event, then text that the halted parser must drop
        finish_stream();
        random_records(60);
        drain();

        if (fail_count == 0 && pending_results.size() == 0)
            $display("intel_hex_record_parser regression: pass");
        else
            $display("intel_hex_record_parser regression: fail");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/ihex_pkg.sv
hw/rtl/ihex_in_reg.sv
hw/rtl/ihex_parser.sv
hw/rtl/ihex_out_reg.sv
hw/rtl/intel_hex_record_parser.sv
hw/rtl/ihex_checker.sv
sim/intel_hex_record_parser_test.sv
